@@ rtl/lc3_pkg.sv @@
// Shared types and constants for the LC-3 instruction executor.
`default_nettype none
package lc3_pkg;
  localparam int MEM_ADDR_BITS = 16;

  localparam logic [1:0] OUTCOME_DONE    = 2'd0;
  localparam logic [1:0] OUTCOME_TRAP    = 2'd1;
  localparam logic [1:0] OUTCOME_ILLEGAL = 2'd2;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_RES  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [2:0] FLAG_Z = 3'b010;

  typedef struct packed {
    logic        operation;
    logic [15:0] mem_address;
    logic [15:0] data;
  } lc3_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] fetched_word;
    logic [15:0] next_pc;
    logic [2:0]  flags_nzp;
    logic [7:0]  trap_vector;
  } lc3_out_t;

  // memory address source select
  localparam logic [1:0] ASEL_LOAD = 2'd0;
  localparam logic [1:0] ASEL_PC   = 2'd1;
  localparam logic [1:0] ASEL_EA   = 2'd2;
  localparam logic [1:0] ASEL_MDR  = 2'd3;

  typedef struct packed {
    logic       load_ir;     // capture memory read data as instruction
    logic       load_mdr;    // capture memory read data as operand
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] addr_sel;
    logic       wr_load;     // write data comes from input transaction
    logic       execute;     // commit register, pc and flag updates
    logic       capture;     // latch input transaction
    logic       emit;        // drive result
    logic       emit_load;   // result of a load transaction
  } lc3_cmd_t;

  typedef struct packed {
    logic       operation;
    logic [3:0] opcode;
  } lc3_status_t;
endpackage
`default_nettype wire

@@ rtl/lc3_datapath.sv @@
// LC-3 datapath: memory, register file, PC, flags and result register.
`default_nettype none
module lc3_datapath
  import lc3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire lc3_in_t     in_txn,
  input  wire lc3_cmd_t    cmd,
  output lc3_status_t      status,
  output lc3_out_t         out_data
);
  logic [15:0] mem [2**MEM_ADDR_BITS];
  logic [15:0] rdata_r;
  logic [15:0] regs_r [8];
  logic [15:0] regs_nxt [8];
  logic [15:0] pc_r, pc_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [15:0] ir_r, mdr_r;
  lc3_in_t     txn_r;
  lc3_out_t    out_r, out_nxt;
  logic [MEM_ADDR_BITS-1:0] addr;
  logic [15:0] wdata;

  logic [3:0]  opc;
  logic [2:0]  dr, sr1;
  logic [15:0] a, b, off9, off6, off11, pc1, ea;
  logic [15:0] wval;
  logic        wen;
  logic [2:0]  widx;
  logic        r7_wen;

  assign opc   = ir_r[15:12];
  assign dr    = ir_r[11:9];
  assign sr1   = ir_r[8:6];
  assign a     = regs_r[sr1];
  assign off9  = {{7{ir_r[8]}}, ir_r[8:0]};
  assign off6  = {{10{ir_r[5]}}, ir_r[5:0]};
  assign off11 = {{5{ir_r[10]}}, ir_r[10:0]};
  assign b     = ir_r[5] ? {{11{ir_r[4]}}, ir_r[4:0]} : regs_r[ir_r[2:0]];
  // pc_r already advanced once the instruction is latched
  assign pc1   = pc_r;
  assign ea    = (opc == OP_LDR || opc == OP_STR) ? a + off6 : pc1 + off9;

  assign status.operation = txn_r.operation;
  assign status.opcode    = opc;

  always_comb begin
    unique case (cmd.addr_sel)
      ASEL_LOAD: addr = txn_r.mem_address[MEM_ADDR_BITS-1:0];
      ASEL_PC:   addr = pc_r[MEM_ADDR_BITS-1:0];
      ASEL_EA:   addr = ea[MEM_ADDR_BITS-1:0];
      default:   addr = mdr_r[MEM_ADDR_BITS-1:0];
    endcase
    wdata = cmd.wr_load ? txn_r.data : regs_r[dr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[addr];
  end

  always_comb begin
    wen    = 1'b0;
    wval   = '0;
    widx   = dr;
    r7_wen = 1'b0;
    pc_nxt = pc_r;
    if (cmd.load_ir) pc_nxt = pc_r + 16'd1;
    if (cmd.execute) begin
      unique case (opc)
        OP_BR:  if ((dr & flags_r) != 3'b000) pc_nxt = pc1 + off9;
        OP_ADD: begin wen = 1'b1; wval = a + b; end
        OP_AND: begin wen = 1'b1; wval = a & b; end
        OP_NOT: begin wen = 1'b1; wval = ~a; end
        OP_LD, OP_LDR, OP_LDI: begin wen = 1'b1; wval = rdata_r; end
        OP_LEA: begin wen = 1'b1; wval = pc1 + off9; end
        OP_JSR: begin
          r7_wen = 1'b1;
          pc_nxt = ir_r[11] ? pc1 + off11 : a;
        end
        OP_JMP: pc_nxt = a;
        default: ;
      endcase
    end
    if (cfg_we) pc_nxt = cfg_wdata;
    for (int i = 0; i < 8; i++) regs_nxt[i] = regs_r[i];
    if (wen) regs_nxt[widx] = wval;
    if (r7_wen) regs_nxt[7] = pc1;
    flags_nxt = flags_r;
    if (wen) begin
      if (wval == 16'd0) flags_nxt = 3'b010;
      else if (wval[15]) flags_nxt = 3'b100;
      else flags_nxt = 3'b001;
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.emit) begin
      out_nxt.next_pc   = pc_nxt;
      out_nxt.flags_nzp = flags_nxt;
      if (cmd.emit_load) begin
        out_nxt.outcome      = OUTCOME_DONE;
        out_nxt.fetched_word = '0;
        out_nxt.trap_vector  = '0;
      end else begin
        out_nxt.fetched_word = ir_r;
        out_nxt.trap_vector  = '0;
        if (opc == OP_TRAP) begin
          out_nxt.outcome     = OUTCOME_TRAP;
          out_nxt.trap_vector = ir_r[7:0];
        end else if (opc == OP_RTI || opc == OP_RES) begin
          out_nxt.outcome = OUTCOME_ILLEGAL;
        end else begin
          out_nxt.outcome = OUTCOME_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= 16'h3000;
      flags_r <= FLAG_Z;
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
    end else begin
      pc_r    <= pc_nxt;
      flags_r <= flags_nxt;
      for (int i = 0; i < 8; i++) regs_r[i] <= regs_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) txn_r <= in_txn;
    if (cmd.load_ir) ir_r <= rdata_r;
    if (cmd.load_mdr) mdr_r <= rdata_r;
    out_r <= out_nxt;
  end

  assign out_data = out_r;
endmodule
`default_nettype wire

@@ rtl/lc3_control.sv @@
// LC-3 controller state machine sequencing fetch, memory access and execute.
`default_nettype none
module lc3_control
  import lc3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire lc3_status_t status,
  output logic             busy,
  output logic             emit_r,
  output lc3_cmd_t         cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_IND   = 3'd4;
  localparam logic [2:0] S_MEM   = 3'd5;
  localparam logic [2:0] S_EXEC  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       emit_nxt;
  logic [3:0] opc;

  assign opc  = status.opcode;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    emit_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = start;
        if (start) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!status.operation) begin
          cmd.addr_sel  = ASEL_LOAD;
          cmd.wr_load   = 1'b1;
          cmd.mem_wr    = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_load = 1'b1;
          emit_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.addr_sel = ASEL_PC;
          cmd.mem_rd   = 1'b1;
          state_nxt    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.load_ir = 1'b1;
        state_nxt   = S_DEC;
      end
      S_DEC: begin
        cmd.addr_sel = ASEL_EA;
        if (opc == OP_LD || opc == OP_LDR || opc == OP_LDI || opc == OP_STI) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = (opc == OP_LDI || opc == OP_STI) ? S_IND : S_EXEC;
        end else if (opc == OP_ST || opc == OP_STR) begin
          cmd.mem_wr = 1'b1;
          state_nxt  = S_EXEC;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_IND: begin
        cmd.load_mdr = 1'b1;
        state_nxt    = S_MEM;
      end
      S_MEM: begin
        cmd.addr_sel = ASEL_MDR;
        if (opc == OP_STI) cmd.mem_wr = 1'b1;
        else cmd.mem_rd = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        cmd.emit    = 1'b1;
        emit_nxt    = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/lc3_instruction_executor.sv @@
// Top level of the LC-3 instruction executor.
// A memory load transaction uses only the load state; an instruction uses load, fetch,
// decode and execute, and LDI and STI add the indirect and memory states before execute.
// busy drops in the strobe cycle; a new transaction is accepted only when busy is low.
// Synchronous active-low reset: PC 0x3000, registers zero, Z flag set.
// Memory contents are not reset; out_valid is a one-cycle strobe.
`default_nettype none
module lc3_instruction_executor
  import lc3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire lc3_in_t     in_txn,
  output logic             out_valid,
  output lc3_out_t         out_txn,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  lc3_cmd_t    cmd;
  lc3_status_t status;

  lc3_control u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .status(status),
    .busy(busy), .emit_r(out_valid), .cmd(cmd)
  );

  lc3_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_txn(in_txn), .cmd(cmd), .status(status), .out_data(out_txn)
  );
endmodule
`default_nettype wire

@@ rtl/lc3_checker.sv @@
// Port-level checker for the LC-3 instruction executor, bound to the top level.
`default_nettype none
module lc3_checker
  import lc3_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire lc3_out_t out_txn
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while still busy");
  a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_txn.outcome != 2'd3)) else $error("bad outcome code");
  a_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_txn.outcome != OUTCOME_TRAP) |-> (out_txn.trap_vector == 8'd0))
    else $error("trap vector without trap");
endmodule

bind lc3_instruction_executor lc3_checker u_lc3_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_txn(out_txn)
);
`default_nettype wire
